@@ design/ldu_pkg.sv @@
// shared types, constants and address helpers for the ldu linear solver
package ldu_pkg;

    localparam int MAX_ORDER = 8;
    localparam int ORDER_W   = $clog2(MAX_ORDER);
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int ACC_W     = 2 * DATA_W;
    localparam int DIVD_W    = DATA_W + FRAC_W;
    localparam int MEM_AW    = 2 + 2 * ORDER_W;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int SIZE_W    = ORDER_W + 1;

    localparam logic [1:0] KIND_COEFF = 2'd0;
    localparam logic [1:0] KIND_RHS   = 2'd1;
    localparam logic [1:0] KIND_START = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_OVFL  = 2'd2;

    localparam logic [1:0] RGN_COEFF = 2'd0;
    localparam logic [1:0] RGN_LOWER = 2'd1;
    localparam logic [1:0] RGN_UPPER = 2'd2;
    localparam logic [1:0] RGN_VEC   = 2'd3;

    localparam logic [ORDER_W-1:0] VEC_RHS  = ORDER_W'(0);
    localparam logic [ORDER_W-1:0] VEC_DIAG = ORDER_W'(1);
    localparam logic [ORDER_W-1:0] VEC_WORK = ORDER_W'(2);

    typedef struct packed {
        logic [1:0]                kind;
        logic [2:0]                row;
        logic [2:0]                col;
        logic signed [DATA_W-1:0]  value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]                index;
        logic signed [DATA_W-1:0]  solution;
        logic                      last;
        logic [1:0]                status;
    } t_out_item;

    typedef struct packed {
        logic                we;
        logic [MEM_AW-1:0]   addr;
        logic [DATA_W-1:0]   wdata;
    } t_mem_req;

    typedef struct packed {
        logic                      done;
        logic                      zero;
        logic                      ovf;
        logic signed [DATA_W-1:0]  quo;
    } t_div_res;

    function automatic logic [MEM_AW-1:0] mat_addr(input logic [1:0] rgn,
                                                   input logic [ORDER_W-1:0] r,
                                                   input logic [ORDER_W-1:0] c);
        return {rgn, r, c};
    endfunction

    function automatic logic [MEM_AW-1:0] vec_addr(input logic [ORDER_W-1:0] sub,
                                                   input logic [ORDER_W-1:0] idx);
        return {RGN_VEC, sub, idx};
    endfunction

endpackage

@@ design/ldu_ram.sv @@
// generic single-port ram with registered read
module ldu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/ldu_div.sv @@
// iterative fixed-point divider, one quotient bit per cycle, saturating
module ldu_div import ldu_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output t_div_res                 o_res
);

    localparam int CNT_W = $clog2(DIVD_W);

    logic              r_busy;
    logic              r_done;
    logic              r_zero;
    logic              r_neg;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_den;
    logic [DIVD_W-1:0] r_quo;

    logic [DATA_W-1:0] num_mag;
    logic [DATA_W-1:0] den_mag;
    logic [DATA_W:0]   rem_sh;
    logic              ge;
    logic [DATA_W:0]   rem_sub;
    logic              pos_ovf;
    logic              neg_ovf;

    assign num_mag = i_num[DATA_W-1] ? (~i_num + DATA_W'(1)) : i_num;
    assign den_mag = i_den[DATA_W-1] ? (~i_den + DATA_W'(1)) : i_den;
    assign rem_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_den == '0) begin
                    r_zero <= 1'b1;
                    r_neg  <= 1'b0;
                    r_quo  <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_zero <= 1'b0;
                    r_neg  <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
                    r_busy <= 1'b1;
                    r_cnt  <= CNT_W'(DIVD_W - 1);
                    r_rem  <= '0;
                    r_den  <= den_mag;
                    r_quo  <= {num_mag, FRAC_W'(0)};
                end
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], ge};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign pos_ovf = |r_quo[DIVD_W-1:DATA_W-1];
    assign neg_ovf = (|r_quo[DIVD_W-1:DATA_W]) |
                     (r_quo[DATA_W-1] & (|r_quo[DATA_W-2:0]));

    always_comb begin
        o_res.done = r_done;
        o_res.zero = r_zero;
        o_res.ovf  = r_neg ? neg_ovf : pos_ovf;
        if (r_neg) begin
            o_res.quo = neg_ovf ? {1'b1, {(DATA_W-1){1'b0}}}
                                : -$signed(r_quo[DATA_W-1:0]);
        end else begin
            o_res.quo = pos_ovf ? {1'b0, {(DATA_W-1){1'b1}}}
                                : $signed(r_quo[DATA_W-1:0]);
        end
    end

endmodule

@@ design/ldu_core.sv @@
// solve sequencer: factorization, substitutions and result delivery over one ram port
module ldu_core import ldu_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [SIZE_W-1:0]   i_n,
    output logic                o_idle,
    output t_mem_req            o_mem,
    input  logic [DATA_W-1:0]   i_rdata,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_item           o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_ITER, S_RA, S_RB, S_CB, S_MUL, S_ACC,
        S_FIN0, S_FIN1, S_DEN, S_DIV, S_OUT, S_NEXT
    } t_state;

    typedef enum logic [2:0] {
        PH_FAC, PH_FWD, PH_DIAG, PH_BACK, PH_OUT
    } t_phase;

    t_state                    r_state;
    t_phase                    r_phase;
    logic [ORDER_W-1:0]        r_i;
    logic [ORDER_W-1:0]        r_j;
    logic [SIZE_W-1:0]         r_k;
    logic [SIZE_W-1:0]         r_kend;
    logic [SIZE_W-1:0]         r_n;
    logic                      r_second;
    logic [1:0]                r_flags;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [DATA_W-1:0]  r_opa;
    logic signed [DATA_W-1:0]  r_opb;
    logic signed [ACC_W-1:0]   r_prod;
    logic signed [DATA_W-1:0]  r_num;
    logic                      r_out_valid;
    t_out_item                 r_out;

    logic [ORDER_W-1:0]        n_m1;
    logic [ORDER_W-1:0]        kx;
    logic signed [ACC_W-1:0]   prod_rnd;
    logic signed [ACC_W-1:0]   rd_ext;
    logic signed [ACC_W-1:0]   diff_full;
    logic signed [DATA_W-1:0]  t_sat;
    logic                      t_ovf;
    logic signed [DATA_W-1:0]  diff_sat;
    logic                      diff_ovf;
    logic                      div_start;
    t_div_res                  div_res;
    logic [ORDER_W-1:0]        min_ij;
    logic [1:0]                status;

    function automatic logic is_ovf(input logic signed [ACC_W-1:0] v);
        return (v > ACC_W'(64'sh7FFF_FFFF)) || (v < -ACC_W'(64'sh8000_0000));
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        if (v > ACC_W'(64'sh7FFF_FFFF)) begin
            return {1'b0, {(DATA_W-1){1'b1}}};
        end else if (v < -ACC_W'(64'sh8000_0000)) begin
            return {1'b1, {(DATA_W-1){1'b0}}};
        end
        return v[DATA_W-1:0];
    endfunction

    assign n_m1      = ORDER_W'(r_n - SIZE_W'(1));
    assign kx        = r_k[ORDER_W-1:0];
    assign min_ij    = (r_i < r_j) ? r_i : r_j;
    assign prod_rnd  = (r_prod + ACC_W'(32768)) >>> FRAC_W;
    assign rd_ext    = ACC_W'($signed(i_rdata));
    assign diff_full = rd_ext - r_acc;
    assign t_sat     = sat32(prod_rnd);
    assign t_ovf     = is_ovf(prod_rnd);
    assign diff_sat  = sat32(diff_full);
    assign diff_ovf  = is_ovf(diff_full);
    assign div_start = (r_state == S_DEN);
    assign status    = r_flags[0] ? ST_ZERO : (r_flags[1] ? ST_OVFL : ST_OK);

    ldu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_num),
        .i_den   ($signed(i_rdata)),
        .o_res   (div_res)
    );

    // ram access per state
    always_comb begin
        o_mem = '{we: 1'b0, addr: '0, wdata: '0};
        case (r_state)
            S_RA: begin
                o_mem.addr = (r_phase == PH_BACK) ? mat_addr(RGN_UPPER, r_i, kx)
                                                  : mat_addr(RGN_LOWER, r_i, kx);
            end
            S_RB: begin
                o_mem.addr = (r_phase == PH_FAC) ? vec_addr(VEC_DIAG, kx)
                                                 : vec_addr(VEC_WORK, kx);
            end
            S_ACC: begin
                o_mem.addr = mat_addr(RGN_UPPER, kx, r_j);
            end
            S_FIN0: begin
                case (r_phase)
                    PH_FAC:  o_mem.addr = mat_addr(RGN_COEFF, r_i, r_j);
                    PH_FWD:  o_mem.addr = vec_addr(VEC_RHS, r_i);
                    default: o_mem.addr = vec_addr(VEC_WORK, r_i);
                endcase
            end
            S_FIN1: begin
                o_mem.wdata = diff_sat;
                case (r_phase)
                    PH_FAC: begin
                        if (r_i == r_j) begin
                            o_mem.we   = 1'b1;
                            o_mem.addr = vec_addr(VEC_DIAG, r_i);
                        end else begin
                            o_mem.addr = vec_addr(VEC_DIAG, min_ij);
                        end
                    end
                    PH_DIAG: o_mem.addr = vec_addr(VEC_DIAG, r_i);
                    PH_FWD, PH_BACK: begin
                        o_mem.we   = 1'b1;
                        o_mem.addr = vec_addr(VEC_WORK, r_i);
                    end
                    default: o_mem.we = 1'b0;
                endcase
            end
            S_DIV: begin
                o_mem.we    = div_res.done;
                o_mem.wdata = div_res.quo;
                if (r_phase == PH_DIAG) begin
                    o_mem.addr = vec_addr(VEC_WORK, r_i);
                end else if (r_i > r_j) begin
                    o_mem.addr = mat_addr(RGN_LOWER, r_i, r_j);
                end else begin
                    o_mem.addr = mat_addr(RGN_UPPER, r_i, r_j);
                end
            end
            default: o_mem.we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_FAC;
            r_i         <= '0;
            r_j         <= '0;
            r_k         <= '0;
            r_kend      <= '0;
            r_n         <= '0;
            r_second    <= 1'b0;
            r_flags     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_n     <= i_n;
                        r_flags <= '0;
                        r_phase <= PH_FAC;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_acc    <= '0;
                    r_second <= 1'b0;
                    case (r_phase)
                        PH_FAC: begin
                            r_k    <= '0;
                            r_kend <= SIZE_W'(min_ij);
                        end
                        PH_FWD: begin
                            r_k    <= '0;
                            r_kend <= SIZE_W'(r_i);
                        end
                        PH_BACK: begin
                            r_k    <= SIZE_W'(r_i) + SIZE_W'(1);
                            r_kend <= r_n;
                        end
                        default: begin
                            r_k    <= '0;
                            r_kend <= '0;
                        end
                    endcase
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_state <= (r_k < r_kend) ? S_RA : S_FIN0;
                end
                S_RA: begin
                    r_state <= S_RB;
                end
                S_RB: begin
                    r_opa   <= $signed(i_rdata);
                    r_state <= S_CB;
                end
                S_CB: begin
                    r_opb   <= $signed(i_rdata);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod  <= r_opa * r_opb;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (r_phase == PH_FAC && !r_second) begin
                        r_opa    <= t_sat;
                        r_second <= 1'b1;
                        if (t_ovf) begin
                            r_flags[1] <= 1'b1;
                        end
                        r_state  <= S_CB;
                    end else begin
                        r_acc    <= r_acc + prod_rnd;
                        r_second <= 1'b0;
                        r_k      <= r_k + SIZE_W'(1);
                        r_state  <= S_ITER;
                    end
                end
                S_FIN0: begin
                    r_state <= S_FIN1;
                end
                S_FIN1: begin
                    r_num <= diff_sat;
                    if (diff_ovf && r_phase != PH_OUT) begin
                        r_flags[1] <= 1'b1;
                    end
                    case (r_phase)
                        PH_FAC:  r_state <= (r_i == r_j) ? S_NEXT : S_DEN;
                        PH_DIAG: r_state <= S_DEN;
                        PH_OUT: begin
                            r_out_valid    <= 1'b1;
                            r_out.index    <= r_i;
                            r_out.solution <= $signed(i_rdata);
                            r_out.last     <= (r_i == n_m1);
                            r_out.status   <= status;
                            r_state        <= S_OUT;
                        end
                        default: r_state <= S_NEXT;
                    endcase
                end
                S_DEN: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_res.done) begin
                        r_flags <= r_flags | {div_res.ovf, div_res.zero};
                        r_state <= S_NEXT;
                    end
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_state <= S_SETUP;
                    case (r_phase)
                        PH_FAC: begin
                            if (r_j == n_m1) begin
                                r_j <= '0;
                                if (r_i == n_m1) begin
                                    r_phase <= PH_FWD;
                                    r_i     <= '0;
                                end else begin
                                    r_i <= r_i + ORDER_W'(1);
                                end
                            end else begin
                                r_j <= r_j + ORDER_W'(1);
                            end
                        end
                        PH_FWD: begin
                            if (r_i == n_m1) begin
                                r_phase <= PH_DIAG;
                                r_i     <= '0;
                            end else begin
                                r_i <= r_i + ORDER_W'(1);
                            end
                        end
                        PH_DIAG: begin
                            if (r_i == n_m1) begin
                                if (n_m1 == '0) begin
                                    r_phase <= PH_OUT;
                                    r_i     <= '0;
                                end else begin
                                    r_phase <= PH_BACK;
                                    r_i     <= n_m1 - ORDER_W'(1);
                                end
                            end else begin
                                r_i <= r_i + ORDER_W'(1);
                            end
                        end
                        PH_BACK: begin
                            if (r_i == '0) begin
                                r_phase <= PH_OUT;
                            end else begin
                                r_i <= r_i - ORDER_W'(1);
                            end
                        end
                        default: begin
                            if (r_i == n_m1) begin
                                r_state <= S_IDLE;
                            end else begin
                                r_i <= r_i + ORDER_W'(1);
                            end
                        end
                    endcase
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_idle      = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/ldu_linear_solver_top.sv @@
// top level of the ldu linear solver: config register, load path and shared ram
//
// solves A x = b (order n = size register, clamped to 1..8) by LDU factoring
// without pivoting, in signed Q16.16.
// input channel (i_in_valid / o_in_ready): kind 0 loads A[row][col], kind 1
// loads b[row], kind 2 starts a solve, kind 3 is dropped; every A and b
// entry in use must be loaded before a start.
// a start runs factoring, forward, diagonal and back substitution through
// one single-port ram, one access per cycle; each division runs in a
// bit-serial divider.
// results (o_out_valid / i_out_ready): x[0..n-1] in index order, last set on
// the final one, status 1 zero pivot, 2 saturation, 0 ok, same on all of a run.
// a stalled receiver holds the solver on the pending result; no new request
// is taken until the last result has gone.
// reset sets n to 8 and idles the sequencer; stored entries are not cleared.
// the size register may be written only while the block is idle.
module ldu_linear_solver_top import ldu_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_item         o_out_data,
    input  logic              i_cfg_we,
    input  logic [3:0]        i_cfg_wdata
);

    logic [3:0]          r_size;
    logic [SIZE_W-1:0]   n_clamped;
    logic                core_idle;
    logic                accept;
    logic                start;
    t_mem_req            core_mem;
    t_mem_req            mem;
    logic [DATA_W-1:0]   rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= 4'(MAX_ORDER);
        end else if (i_cfg_we) begin
            r_size <= i_cfg_wdata;
        end
    end

    always_comb begin
        if (r_size == 4'd0) begin
            n_clamped = SIZE_W'(1);
        end else if (r_size > 4'(MAX_ORDER)) begin
            n_clamped = SIZE_W'(MAX_ORDER);
        end else begin
            n_clamped = SIZE_W'(r_size);
        end
    end

    assign o_in_ready = core_idle;
    assign accept     = i_in_valid & core_idle;
    assign start      = accept && (i_in_data.kind == KIND_START);

    always_comb begin
        mem = core_mem;
        if (accept) begin
            case (i_in_data.kind)
                KIND_COEFF: begin
                    mem.we    = 1'b1;
                    mem.addr  = mat_addr(RGN_COEFF, i_in_data.row, i_in_data.col);
                    mem.wdata = i_in_data.value;
                end
                KIND_RHS: begin
                    mem.we    = 1'b1;
                    mem.addr  = vec_addr(VEC_RHS, i_in_data.row);
                    mem.wdata = i_in_data.value;
                end
                default: mem = core_mem;
            endcase
        end
    end

    ldu_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_addr  (mem.addr),
        .i_wdata (mem.wdata),
        .o_rdata (rdata)
    );

    ldu_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_n         (n_clamped),
        .o_idle      (core_idle),
        .o_mem       (core_mem),
        .i_rdata     (rdata),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
